// ===== rtl/ledtw_pkg.sv =====
// shared types, codes and constants for the two-wire led driver sequencer
package ledtw_pkg;

  localparam int DisplayBytesDefault = 16;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_BURST  = 3'd2;
  localparam logic [2:0] OP_FIXED  = 3'd3;
  localparam logic [2:0] OP_BRIGHT = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [7:0] CMD_AUTO_INC  = 8'h40;
  localparam logic [7:0] CMD_FIXED_ADR = 8'h44;
  localparam logic [7:0] CMD_ADDR_BASE = 8'hC0;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h88;

  localparam logic [4:0] COND_STEPS     = 5'd4;
  localparam logic [4:0] BYTE_STEPS     = 5'd25;
  localparam logic [4:0] BYTE_LAST_STEP = 5'd24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START1,
    ST_CMD,
    ST_STOP1,
    ST_START2,
    ST_ADDR,
    ST_DATA,
    ST_STOP2
  } stage_t;

  typedef struct packed {
    logic rejected;
    logic busy_res;
    logic data_pin;
    logic clock_pin;
  } result_t;

endpackage

// ===== rtl/ledtw_seq.sv =====
// bus sequencer: display buffer, pin stepping and per-item result
module ledtw_seq #(
  parameter int DISPLAY_BYTES = ledtw_pkg::DisplayBytesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [2:0]          op,
  input  logic [3:0]          address,
  input  logic [7:0]          data_byte,
  input  logic [2:0]          brightness,
  output ledtw_pkg::result_t  result
);

  localparam int IdxW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;
  localparam logic [4:0] BufLen = 5'(DISPLAY_BYTES);

  logic [7:0] buf_r [DISPLAY_BYTES];

  ledtw_pkg::stage_t stage_r, stage_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [4:0] sent_r, sent_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] active_r, active_nxt;
  logic [3:0] hold_addr_r, hold_addr_nxt;
  logic [7:0] hold_data_r, hold_data_nxt;
  logic       clk_lvl_r, clk_lvl_nxt;
  logic       dat_lvl_r, dat_lvl_nxt;
  logic       rej;
  logic       buf_we;

  function automatic logic [7:0] byte_at(input logic [2:0] cmd, input logic [7:0] hdata,
                                         input logic [7:0] bval);
    logic [7:0] r;
    r = 8'h00;
    if (cmd == ledtw_pkg::OP_FIXED) r = hdata;
    else if (cmd == ledtw_pkg::OP_BURST) r = bval;
    return r;
  endfunction

  // next state
  always_comb begin
    logic       tick;
    logic [4:0] step_inc;
    logic [4:0] len;
    logic [4:0] nsent;
    logic [4:0] cnt;
    stage_nxt     = stage_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    sent_nxt      = sent_r;
    shift_nxt     = shift_r;
    active_nxt    = active_r;
    hold_addr_nxt = hold_addr_r;
    hold_data_nxt = hold_data_r;
    clk_lvl_nxt   = clk_lvl_r;
    dat_lvl_nxt   = dat_lvl_r;
    rej           = 1'b0;
    buf_we        = 1'b0;
    tick          = 1'b0;
    step_inc      = 5'd0;
    len           = ledtw_pkg::BYTE_STEPS;
    nsent         = 5'd0;
    cnt           = 5'd0;

    if (stage_r != ledtw_pkg::ST_IDLE) begin
      rej  = (op inside {[ledtw_pkg::OP_LOAD:ledtw_pkg::OP_CLEAR]});
      tick = 1'b1;
    end else if (op == ledtw_pkg::OP_LOAD) begin
      buf_we = ({1'b0, address} < BufLen);
    end else if (op inside {[ledtw_pkg::OP_BURST:ledtw_pkg::OP_CLEAR]}) begin
      active_nxt    = op;
      hold_addr_nxt = address;
      hold_data_nxt = (op == ledtw_pkg::OP_BRIGHT) ?
                      (ledtw_pkg::CMD_DISP_CTRL | {5'd0, brightness}) : data_byte;
      stage_nxt     = ledtw_pkg::ST_START1;
      step_nxt      = 5'd0;
      phase_nxt     = 2'd0;
      bit_nxt       = 3'd0;
      sent_nxt      = 5'd0;
      tick          = 1'b1;
    end

    if (tick) begin
      case (stage_nxt)
        ledtw_pkg::ST_START1, ledtw_pkg::ST_START2: begin
          len = ledtw_pkg::COND_STEPS;
          case (step_nxt)
            5'd0:    clk_lvl_nxt = 1'b1;
            5'd1:    dat_lvl_nxt = 1'b1;
            5'd2:    dat_lvl_nxt = 1'b0;
            default: clk_lvl_nxt = 1'b0;
          endcase
        end
        ledtw_pkg::ST_STOP1, ledtw_pkg::ST_STOP2: begin
          len = ledtw_pkg::COND_STEPS;
          case (step_nxt)
            5'd0:    clk_lvl_nxt = 1'b0;
            5'd1:    dat_lvl_nxt = 1'b0;
            5'd2:    clk_lvl_nxt = 1'b1;
            default: dat_lvl_nxt = 1'b1;
          endcase
        end
        default: begin
          len = ledtw_pkg::BYTE_STEPS;
          if (step_nxt >= ledtw_pkg::BYTE_LAST_STEP) begin
            clk_lvl_nxt = 1'b0;
          end else begin
            case (phase_nxt)
              2'd0:    clk_lvl_nxt = 1'b0;
              2'd1:    dat_lvl_nxt = shift_nxt[bit_nxt];
              default: clk_lvl_nxt = 1'b1;
            endcase
          end
        end
      endcase

      step_inc = step_nxt + 5'd1;
      if (step_inc >= len) begin
        step_nxt  = 5'd0;
        phase_nxt = 2'd0;
        bit_nxt   = 3'd0;
        case (stage_nxt)
          ledtw_pkg::ST_START1: begin
            stage_nxt = ledtw_pkg::ST_CMD;
            if (active_nxt == ledtw_pkg::OP_FIXED) shift_nxt = ledtw_pkg::CMD_FIXED_ADR;
            else if (active_nxt == ledtw_pkg::OP_BRIGHT) shift_nxt = hold_data_nxt;
            else shift_nxt = ledtw_pkg::CMD_AUTO_INC;
          end
          ledtw_pkg::ST_CMD: stage_nxt = ledtw_pkg::ST_STOP1;
          ledtw_pkg::ST_STOP1: begin
            if (active_nxt == ledtw_pkg::OP_BRIGHT) begin
              stage_nxt  = ledtw_pkg::ST_IDLE;
              active_nxt = ledtw_pkg::OP_TICK;
            end else begin
              stage_nxt = ledtw_pkg::ST_START2;
            end
          end
          ledtw_pkg::ST_START2: begin
            stage_nxt = ledtw_pkg::ST_ADDR;
            shift_nxt = ledtw_pkg::CMD_ADDR_BASE |
                        ((active_nxt == ledtw_pkg::OP_FIXED) ? {4'd0, hold_addr_nxt} : 8'h00);
          end
          ledtw_pkg::ST_ADDR: begin
            stage_nxt = ledtw_pkg::ST_DATA;
            sent_nxt  = 5'd0;
            shift_nxt = byte_at(active_nxt, hold_data_nxt, buf_r[0]);
          end
          ledtw_pkg::ST_DATA: begin
            cnt      = (active_nxt == ledtw_pkg::OP_FIXED) ? 5'd1 : BufLen;
            nsent    = sent_nxt + 5'd1;
            sent_nxt = nsent;
            if (nsent < cnt)
              shift_nxt = byte_at(active_nxt, hold_data_nxt, buf_r[nsent[IdxW-1:0]]);
            else
              stage_nxt = ledtw_pkg::ST_STOP2;
          end
          default: begin
            stage_nxt  = ledtw_pkg::ST_IDLE;
            active_nxt = ledtw_pkg::OP_TICK;
          end
        endcase
      end else begin
        step_nxt = step_inc;
        if (phase_nxt == 2'd2) begin
          phase_nxt = 2'd0;
          bit_nxt   = bit_nxt + 3'd1;
        end else begin
          phase_nxt = phase_nxt + 2'd1;
        end
      end
    end
  end

  // result of this transaction
  always_comb begin
    result.clock_pin = clk_lvl_nxt;
    result.data_pin  = dat_lvl_nxt;
    result.busy_res  = (stage_nxt != ledtw_pkg::ST_IDLE);
    result.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ledtw_pkg::ST_IDLE;
      step_r      <= 5'd0;
      phase_r     <= 2'd0;
      bit_r       <= 3'd0;
      sent_r      <= 5'd0;
      shift_r     <= 8'h00;
      active_r    <= ledtw_pkg::OP_TICK;
      hold_addr_r <= 4'd0;
      hold_data_r <= 8'h00;
      clk_lvl_r   <= 1'b1;
      dat_lvl_r   <= 1'b1;
    end else if (fire) begin
      stage_r     <= stage_nxt;
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      sent_r      <= sent_nxt;
      shift_r     <= shift_nxt;
      active_r    <= active_nxt;
      hold_addr_r <= hold_addr_nxt;
      hold_data_r <= hold_data_nxt;
      clk_lvl_r   <= clk_lvl_nxt;
      dat_lvl_r   <= dat_lvl_nxt;
    end
  end

  // display buffer, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DISPLAY_BYTES; i++) begin
        buf_r[i] <= 8'h00;
      end
    end else if (fire && buf_we) begin
      buf_r[address[IdxW-1:0]] <= data_byte;
    end
  end

endmodule

// ===== rtl/led_driver_two_wire_sequencer_core.sv =====
// top level: input register, sequencer and result register with stream handshakes
//
// Every transaction on the input stream (op, address, data_byte) gives exactly one
// result transaction (clock_pin, data_pin, busy_res, rejected). One item is taken
// per clock cycle; a result is presented once its item has passed an input register
// and the result has been captured in an output register. The
// whole sequencer step, including any command start and the move to the next bus
// element, is done combinationally between those registers, so the sequencer
// state loop never stalls the stream. Backpressure on the result side holds the
// input register and, through it, the input stream. The brightness register is
// written through the cfg port, which is always ready; write it only while no
// transaction is in flight, as a brightness command picks the level up when it
// leaves the input register.
module led_driver_two_wire_sequencer_core #(
  parameter int DISPLAY_BYTES = ledtw_pkg::DisplayBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[2:0], address[6:3], data_byte[14:7], zero[15]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // clock_pin[0], data_pin[1], busy_res[2], rejected[3]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  logic               s1_valid_r;
  logic [2:0]         s1_op_r;
  logic [3:0]         s1_addr_r;
  logic [7:0]         s1_data_r;
  logic               out_valid_r;
  ledtw_pkg::result_t out_res_r;
  ledtw_pkg::result_t res;
  logic [2:0]         bright_r;
  logic               advance;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_res_r};
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 3'd0;
    end else if (cfg_valid) begin
      bright_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tdata[2:0];
      s1_addr_r <= in_tdata[6:3];
      s1_data_r <= in_tdata[14:7];
    end
  end

  ledtw_seq #(
    .DISPLAY_BYTES(DISPLAY_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .op        (s1_op_r),
    .address   (s1_addr_r),
    .data_byte (s1_data_r),
    .brightness(bright_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

endmodule

// ===== rtl/ledtw_chk.sv =====
// port-level checker for the two-wire led driver sequencer, bound to the top level
module ledtw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       cfg_ready
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with no bus sequence running both pins rest high
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[0] && out_tdata[1])
    else $error("pins not high while idle");

  // brightness register always takes a write
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind led_driver_two_wire_sequencer_core ledtw_chk u_ledtw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .cfg_ready (cfg_ready)
);
